/* rtl/core/tmsa_pkg.sv */
`default_nettype none

package tmsa_pkg;

    // Vertex store geometry. The index fields are fixed at ten bits.
    localparam int VERTEX_DEPTH = 1024;
    localparam int VTX_AW       = $clog2(VERTEX_DEPTH);

    // Widths of the arithmetic.
    localparam int EDGE_W  = 17;   // difference of two Q8.8 coordinates
    localparam int MUL_W   = 18;   // operand width of the shared multiplier
    localparam int PROD_W  = 36;   // product width of the shared multiplier
    localparam int MAG_W   = 34;   // magnitude of one cross product component
    localparam int HALF_W  = 17;   // low half of a magnitude for the squaring passes
    localparam int SQ_W    = 70;   // squared length of the cross product
    localparam int ROOT_W  = 35;   // floor square root of the squared length
    localparam int REM_W   = 36;   // partial remainder of the root iteration
    localparam int AREA_W  = 48;   // running area sum

    localparam int ROOT_STEPS = ROOT_W;

    // Input item.
    typedef struct packed {
        logic               cmd;
        logic [9:0]         vertex_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic [9:0]         corner_a;
        logic [9:0]         corner_b;
        logic [9:0]         corner_c;
        logic               final_face;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [AREA_W-1:0] area_total;
        logic              overflowed;
        logic              mesh_done;
    } t_out_item;

    // Input command codes.
    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_FACE   = 1'b1;

    // Vertex store read address select.
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_A = 2'd0;
    localparam t_rd_sel RD_B = 2'd1;
    localparam t_rd_sel RD_C = 2'd2;

    // Multiplier pass kinds.
    typedef logic [2:0] t_mul_kind;
    localparam t_mul_kind MK_CROSS_A = 3'd0;  // first product of a cross component
    localparam t_mul_kind MK_CROSS_B = 3'd1;  // second product, subtracted
    localparam t_mul_kind MK_SQ_HH   = 3'd2;  // high half times high half
    localparam t_mul_kind MK_SQ_HL   = 3'd3;  // high half times low half
    localparam t_mul_kind MK_SQ_LL   = 3'd4;  // low half times low half

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      vtx_wr;
        logic      start_face;
        t_rd_sel   rd_sel;
        logic      ld_a;
        logic      ld_e1;
        logic      ld_e2;
        logic      mul_go;
        t_mul_kind mul_kind;
        logic [1:0] mul_comp;
        logic      root_init;
        logic      root_step;
        logic      sum_go;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* rtl/core/tmsa_ctrl.sv */
`default_nettype none

module tmsa_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_cmd,
    output logic                o_in_ready,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output tmsa_pkg::t_dp_cmd   o_cmd
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RD_B      = 4'd1;
    localparam logic [3:0] ST_RD_C      = 4'd2;
    localparam logic [3:0] ST_EDGE      = 4'd3;
    localparam logic [3:0] ST_MUL       = 4'd4;
    localparam logic [3:0] ST_DRAIN     = 4'd5;
    localparam logic [3:0] ST_ROOT_INIT = 4'd6;
    localparam logic [3:0] ST_ROOT      = 4'd7;
    localparam logic [3:0] ST_SUM       = 4'd8;

    localparam int ITER_W = $clog2(tmsa_pkg::ROOT_STEPS);

    logic [3:0]        r_state, n_state;
    logic              r_sq_phase, n_sq_phase;
    logic [1:0]        r_comp, n_comp;
    logic [1:0]        r_part, n_part;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_out_valid, n_out_valid;
    logic              in_fire;
    logic              out_free;

    // The input is held off while reset is asserted.
    assign o_in_ready  = i_rst_n && (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_sq_phase  = r_sq_phase;
        n_comp      = r_comp;
        n_part      = r_part;
        n_iter      = r_iter;
        n_out_valid = r_out_valid && !i_out_ready;

        o_cmd            = '0;
        o_cmd.rd_sel     = tmsa_pkg::RD_A;
        o_cmd.mul_kind   = tmsa_pkg::MK_CROSS_A;
        o_cmd.mul_comp   = r_comp;

        unique case (r_state)
            ST_IDLE: begin
                o_cmd.rd_sel = tmsa_pkg::RD_A;
                if (in_fire) begin
                    if (i_in_cmd == tmsa_pkg::CMD_FACE) begin
                        o_cmd.start_face = 1'b1;
                        n_state          = ST_RD_B;
                    end else begin
                        o_cmd.vtx_wr = 1'b1;
                    end
                end
            end
            ST_RD_B: begin
                o_cmd.rd_sel = tmsa_pkg::RD_B;
                o_cmd.ld_a   = 1'b1;
                n_state      = ST_RD_C;
            end
            ST_RD_C: begin
                o_cmd.rd_sel = tmsa_pkg::RD_C;
                o_cmd.ld_e1  = 1'b1;
                n_state      = ST_EDGE;
            end
            ST_EDGE: begin
                o_cmd.ld_e2 = 1'b1;
                n_sq_phase  = 1'b0;
                n_comp      = 2'd0;
                n_part      = 2'd0;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul_go = 1'b1;
                if (!r_sq_phase) begin
                    // Two products per cross product component.
                    o_cmd.mul_kind = r_part[0] ? tmsa_pkg::MK_CROSS_B
                                               : tmsa_pkg::MK_CROSS_A;
                    if (r_part[0]) begin
                        n_part = 2'd0;
                        if (r_comp == 2'd2) begin
                            n_comp     = 2'd0;
                            n_sq_phase = 1'b1;
                        end else begin
                            n_comp = r_comp + 2'd1;
                        end
                    end else begin
                        n_part = 2'd1;
                    end
                end else begin
                    // Three partial products per squared magnitude.
                    priority case (r_part)
                        2'd0:    o_cmd.mul_kind = tmsa_pkg::MK_SQ_HH;
                        2'd1:    o_cmd.mul_kind = tmsa_pkg::MK_SQ_HL;
                        default: o_cmd.mul_kind = tmsa_pkg::MK_SQ_LL;
                    endcase
                    if (r_part == 2'd2) begin
                        n_part = 2'd0;
                        if (r_comp == 2'd2) begin
                            n_comp  = 2'd0;
                            n_state = ST_DRAIN;
                        end else begin
                            n_comp = r_comp + 2'd1;
                        end
                    end else begin
                        n_part = r_part + 2'd1;
                    end
                end
            end
            ST_DRAIN: begin
                n_state = ST_ROOT_INIT;
            end
            ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_iter          = '0;
                n_state         = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_iter == ITER_W'(tmsa_pkg::ROOT_STEPS - 1)) begin
                    n_state = ST_SUM;
                end else begin
                    n_iter = r_iter + ITER_W'(1);
                end
            end
            ST_SUM: begin
                if (out_free) begin
                    o_cmd.sum_go = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sq_phase  <= 1'b0;
            r_comp      <= 2'd0;
            r_part      <= 2'd0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sq_phase  <= n_sq_phase;
            r_comp      <= n_comp;
            r_part      <= n_part;
            r_iter      <= n_iter;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tmsa_dp.sv */
`default_nettype none

module tmsa_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  tmsa_pkg::t_in_item  i_in,
    input  tmsa_pkg::t_dp_cmd   i_cmd,
    output tmsa_pkg::t_out_item o_out
);

    localparam int EW = tmsa_pkg::EDGE_W;
    localparam int MW = tmsa_pkg::MUL_W;
    localparam int PW = tmsa_pkg::PROD_W;
    localparam int GW = tmsa_pkg::MAG_W;
    localparam int HW = tmsa_pkg::HALF_W;
    localparam int SW = tmsa_pkg::SQ_W;
    localparam int QW = tmsa_pkg::ROOT_W;
    localparam int RW = tmsa_pkg::REM_W;
    localparam int AW = tmsa_pkg::AREA_W;

    // Vertex store: {z, y, x}, one write and one registered read per cycle.
    logic [47:0]                 r_vtx_mem [tmsa_pkg::VERTEX_DEPTH];
    logic [47:0]                 r_rd_data;
    logic [tmsa_pkg::VTX_AW-1:0] rd_addr;

    logic [9:0]                  r_idx_b, r_idx_c;
    logic                        r_final;
    logic [47:0]                 r_va;
    logic signed [EW-1:0]        r_e1 [3];
    logic signed [EW-1:0]        r_e2 [3];
    logic signed [EW-1:0]        n_edge [3];

    logic [1:0]                  i1, i2;
    logic [GW-1:0]               sel_mag;
    logic signed [MW-1:0]        op_a, op_b;
    logic signed [PW-1:0]        r_prod;
    logic                        r_acc_go;
    tmsa_pkg::t_mul_kind         r_acc_kind;
    logic [1:0]                  r_acc_comp;
    logic signed [PW-1:0]        r_acc;
    logic signed [PW-1:0]        diff;
    logic [PW-1:0]               diff_abs;
    logic [GW-1:0]               r_mag [3];
    logic [SW-1:0]               r_sq, n_sq;

    logic [SW-1:0]               r_rad;
    logic [RW-1:0]               r_rem;
    logic [QW-1:0]               r_root;
    logic [RW+1:0]               rem_sh, trial, rem_sub;

    logic [AW-1:0]               r_area;
    logic                        r_sat;
    logic [AW:0]                 sum_wide;
    logic [AW-1:0]               n_area;
    logic                        n_sat;
    tmsa_pkg::t_out_item         r_out;

    // Vertex store access.
    always_comb begin
        unique case (i_cmd.rd_sel)
            tmsa_pkg::RD_B: rd_addr = r_idx_b[tmsa_pkg::VTX_AW-1:0];
            tmsa_pkg::RD_C: rd_addr = r_idx_c[tmsa_pkg::VTX_AW-1:0];
            default:        rd_addr = i_in.corner_a[tmsa_pkg::VTX_AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_wr) begin
            r_vtx_mem[i_in.vertex_index[tmsa_pkg::VTX_AW-1:0]] <=
                {i_in.coord_z, i_in.coord_y, i_in.coord_x};
        end
        r_rd_data <= r_vtx_mem[rd_addr];
    end

    // Edge vectors relative to the first corner.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_edge[k] = $signed({r_rd_data[16*k+15], r_rd_data[16*k +: 16]})
                      - $signed({r_va[16*k+15], r_va[16*k +: 16]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_face) begin
            r_idx_b <= i_in.corner_b;
            r_idx_c <= i_in.corner_c;
            r_final <= i_in.final_face;
        end
        if (i_cmd.ld_a) begin
            r_va <= r_rd_data;
        end
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.ld_e1) begin
                r_e1[k] <= n_edge[k];
            end
            if (i_cmd.ld_e2) begin
                r_e2[k] <= n_edge[k];
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (i_cmd.mul_comp)
            2'd0: begin
                i1      = 2'd1;
                i2      = 2'd2;
                sel_mag = r_mag[0];
            end
            2'd1: begin
                i1      = 2'd2;
                i2      = 2'd0;
                sel_mag = r_mag[1];
            end
            default: begin
                i1      = 2'd0;
                i2      = 2'd1;
                sel_mag = r_mag[2];
            end
        endcase

        unique case (i_cmd.mul_kind)
            tmsa_pkg::MK_CROSS_A: begin
                op_a = MW'(r_e1[i1]);
                op_b = MW'(r_e2[i2]);
            end
            tmsa_pkg::MK_CROSS_B: begin
                op_a = MW'(r_e1[i2]);
                op_b = MW'(r_e2[i1]);
            end
            tmsa_pkg::MK_SQ_HH: begin
                op_a = {1'b0, sel_mag[GW-1:HW]};
                op_b = {1'b0, sel_mag[GW-1:HW]};
            end
            tmsa_pkg::MK_SQ_HL: begin
                op_a = {1'b0, sel_mag[GW-1:HW]};
                op_b = {1'b0, sel_mag[HW-1:0]};
            end
            default: begin
                op_a = {1'b0, sel_mag[HW-1:0]};
                op_b = {1'b0, sel_mag[HW-1:0]};
            end
        endcase
    end

    // Accumulation of the registered product.
    assign diff     = r_acc - r_prod;
    assign diff_abs = diff[PW-1] ? PW'(-diff) : PW'(diff);

    always_comb begin
        n_sq = r_sq;
        if (r_acc_go) begin
            unique case (r_acc_kind)
                tmsa_pkg::MK_SQ_HH: n_sq = r_sq + {2'b0, r_prod[GW-1:0], 34'b0};
                tmsa_pkg::MK_SQ_HL: n_sq = r_sq + {18'b0, r_prod[GW-1:0], 18'b0};
                tmsa_pkg::MK_SQ_LL: n_sq = r_sq + {36'b0, r_prod[GW-1:0]};
                default:            n_sq = r_sq;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= op_a * op_b;
        r_acc_kind <= i_cmd.mul_kind;
        r_acc_comp <= i_cmd.mul_comp;
        if (i_cmd.start_face) begin
            r_sq <= '0;
        end else begin
            r_sq <= n_sq;
        end
        if (r_acc_go && r_acc_kind == tmsa_pkg::MK_CROSS_A) begin
            r_acc <= r_prod;
        end
        for (int k = 0; k < 3; k++) begin
            if (r_acc_go && r_acc_kind == tmsa_pkg::MK_CROSS_B && r_acc_comp == 2'(k)) begin
                r_mag[k] <= diff_abs[GW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_go <= 1'b0;
        end else begin
            r_acc_go <= i_cmd.mul_go;
        end
    end

    // Restoring square root, one result bit per step.
    assign rem_sh  = {r_rem, r_rad[SW-1:SW-2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_rad  <= r_sq;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[SW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sub[RW-1:0];
                r_root <= {r_root[QW-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[RW-1:0];
                r_root <= {r_root[QW-2:0], 1'b0};
            end
        end
    end

    // Saturating running sum.
    assign sum_wide = {1'b0, r_area} + (AW+1)'(r_root);

    always_comb begin
        if (sum_wide[AW]) begin
            n_area = '1;
            n_sat  = 1'b1;
        end else begin
            n_area = sum_wide[AW-1:0];
            n_sat  = r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area <= '0;
            r_sat  <= 1'b0;
        end else if (i_cmd.sum_go) begin
            r_area <= r_final ? '0 : n_area;
            r_sat  <= r_final ? 1'b0 : n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_go) begin
            r_out.area_total <= n_area;
            r_out.overflowed <= n_sat;
            r_out.mesh_done  <= r_final;
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

/* rtl/core/triangle_mesh_surface_area.sv */
`default_nettype none

// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_ready   i_in  (tmsa_pkg::t_in_item)
// result    out        o_out_valid / i_out_ready o_out (tmsa_pkg::t_out_item)
//
// A vertex write is a one-cycle transfer and the input stays ready for the next one.
// A face holds the input off after its transfer while it runs the corner store reads, the edge load,
// fifteen passes of the shared 18x18 multiplier, a drain state, root setup, 35 root steps
// and the sum update. Reset is synchronous and active low; it clears the sum, the flag and
// the handshake state but not the vertex store, and the input is not ready while it is held.
// A result waiting for its transfer stalls only the sum update of the next face.
module triangle_mesh_surface_area (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tmsa_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tmsa_pkg::t_out_item o_out
);

    tmsa_pkg::t_dp_cmd dp_cmd;

    // The controller sequences each face through the vertex reads, the
    // multiplier passes, the root iterations and the final sum update.
    tmsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_cmd    (i_in.cmd),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // The datapath holds the vertex store, the edge and cross product
    // registers, the square root unit, the running sum and the result.
    tmsa_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (dp_cmd),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

/* tb/triangle_mesh_surface_area_check.sv */
`timescale 1ns / 1ps

module triangle_mesh_surface_area_check
    import tmsa_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    input  wire       i_in_ready,
    input  t_in_item  i_in,
    input  wire       i_out_valid,
    input  wire       i_out_ready,
    input  t_out_item i_out,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int CROSS_W = MAG_W + 2;
    localparam logic [AREA_W:0] AREA_CAP = {1'b0, {AREA_W{1'b1}}};

    logic [47:0]       vertex_mem [VERTEX_DEPTH];
    logic [AREA_W-1:0] area_acc;
    logic              acc_saturated;
    t_out_item         area_expected [$];

    // Twice the triangle area in Q16.16: floor root of the squared cross product length.
    function automatic logic [ROOT_W-1:0] doubled_area(input logic [47:0] va,
                                                       input logic [47:0] vb,
                                                       input logic [47:0] vc);
        logic signed [EDGE_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [CROSS_W-1:0] nx, ny, nz;
        logic [CROSS_W-1:0]        mx, my, mz;
        logic [71:0]               len_sq, trial;
        logic [ROOT_W-1:0]         root;
        e1x = $signed(vb[15:0])  - $signed(va[15:0]);
        e1y = $signed(vb[31:16]) - $signed(va[31:16]);
        e1z = $signed(vb[47:32]) - $signed(va[47:32]);
        e2x = $signed(vc[15:0])  - $signed(va[15:0]);
        e2y = $signed(vc[31:16]) - $signed(va[31:16]);
        e2z = $signed(vc[47:32]) - $signed(va[47:32]);
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        mx = (nx < 0) ? -nx : nx;
        my = (ny < 0) ? -ny : ny;
        mz = (nz < 0) ? -nz : nz;
        len_sq = mx * mx + my * my + mz * mz;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = 72'(root) | (72'd1 << b);
            if (trial * trial <= len_sq) begin
                root = trial[ROOT_W-1:0];
            end
        end
        return root;
    endfunction

    task automatic log_fault(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out_item         want;
        logic [AREA_W:0]   next_sum;
        if (!i_rst_n) begin
            area_acc      = '0;
            acc_saturated = 1'b0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                if (i_in.cmd == CMD_VERTEX) begin
                    if (i_in.vertex_index < VERTEX_DEPTH) begin
                        vertex_mem[i_in.vertex_index] = {i_in.coord_z, i_in.coord_y, i_in.coord_x};
                    end
                end else begin
                    next_sum = area_acc + doubled_area(vertex_mem[i_in.corner_a],
                                                       vertex_mem[i_in.corner_b],
                                                       vertex_mem[i_in.corner_c]);
                    if (next_sum > AREA_CAP) begin
                        area_acc      = '1;
                        acc_saturated = 1'b1;
                    end else begin
                        area_acc = next_sum[AREA_W-1:0];
                    end
                    want.area_total = area_acc;
                    want.overflowed = acc_saturated;
                    want.mesh_done  = i_in.final_face;
                    area_expected = {area_expected, want};
                    if (i_in.final_face) begin
                        area_acc      = '0;
                        acc_saturated = 1'b0;
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (area_expected.size() == 0) begin
                    log_fault($sformatf("unexpected result: area %0d ovf %0b done %0b",
                                        i_out.area_total, i_out.overflowed, i_out.mesh_done));
                end else begin
                    want = area_expected.pop_front();
                    if (i_out.area_total !== want.area_total ||
                        i_out.overflowed !== want.overflowed ||
                        i_out.mesh_done !== want.mesh_done) begin
                        log_fault($sformatf({"result mismatch: expected area %0d ovf %0b done %0b,",
                                             " got area %0d ovf %0b done %0b"},
                                            want.area_total, want.overflowed, want.mesh_done,
                                            i_out.area_total, i_out.overflowed, i_out.mesh_done));
                    end
                end
            end
        end
        o_pending = area_expected.size();
    end

endmodule

/* tb/triangle_mesh_surface_area_test.sv */
`timescale 1ns / 1ps

module triangle_mesh_surface_area_test;
    import tmsa_pkg::*;

    // A face holds the input off only while it is processed, so reaching STALL_LIMIT without any
    // transfer on either channel can only mean the block has hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int CALM_TAIL    = 150;
    // The largest triangle the coordinate range allows doubles to about
    // 7.44e9 in Q16.16; a burst of them carries deep into the 48-bit sum.
    localparam int WIDE_FACES   = 24;
    localparam int DRAIN_CYCLES = 120;

    localparam logic signed [15:0] Q_LO  = 16'sh8000;
    localparam logic signed [15:0] Q_HI  = 16'sh7FFF;
    localparam logic signed [15:0] Q_ONE = 16'sh0100;
    localparam logic signed [15:0] Q_NEG = 16'shFFFF;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;

    int fail_count;
    int pending;
    int idle_cycles;
    bit calm;

    // Slots that hold a vertex; faces only ever name these.
    int written_slots [$];
    bit slot_written [VERTEX_DEPTH];

    triangle_mesh_surface_area dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    triangle_mesh_surface_area_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out        (o_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // The watchdog restarts on every transfer in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side backpressure: long runs of ready broken by random stalls.
    // Once the run turns calm, ready simply stays high.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // Coordinates lean toward the ends of the Q8.8 range and the values
    // around zero, where sign handling in the edge vectors is most fragile.
    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 7))
            0:       return Q_LO;
            1:       return Q_HI;
            2:       return '0;
            3:       return Q_NEG;
            default: return 16'($urandom());
        endcase
    endfunction

    // A fresh item with every field random, so the fields that a command
    // ignores carry noise.
    function automatic t_in_item noisy_item();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(t_in_item)-1:0];
    endfunction

    // Presents one item and returns at the edge of its transfer. Valid stays
    // high afterwards, so back to back items follow without a gap; a random
    // gap lowers it first.
    task automatic send_item(input t_in_item item);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_vertex(input int slot, input logic signed [15:0] x,
                                input logic signed [15:0] y, input logic signed [15:0] z);
        t_in_item item;
        item              = noisy_item();
        item.cmd          = CMD_VERTEX;
        item.vertex_index = 10'(slot);
        item.coord_x      = x;
        item.coord_y      = y;
        item.coord_z      = z;
        send_item(item);
        if (!slot_written[slot]) begin
            slot_written[slot] = 1'b1;
            written_slots = {written_slots, slot};
        end
    endtask

    task automatic send_face(input int a, input int b, input int c, input bit last);
        t_in_item item;
        item            = noisy_item();
        item.cmd        = CMD_FACE;
        item.corner_a   = 10'(a);
        item.corner_b   = 10'(b);
        item.corner_c   = 10'(c);
        item.final_face = last;
        send_item(item);
    endtask

    // Drops valid and holds the input side off until every face sent so far
    // has produced its result. The pending count is sampled on the falling
    // edge so that it already reflects the transfer at the previous rising edge.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic int any_written_slot();
        return written_slots[$urandom_range(0, written_slots.size() - 1)];
    endfunction

    initial begin
        int a, b, c;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        calm        = 1'b0;
        idle_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Slots 0, 1023 and 512 hold three corners of the
        // coordinate cube whose edge vectors span the widest possible
        // triangle; slots 341 and 682 use alternating index bits.
        write_vertex(0,    Q_LO, Q_LO, Q_LO);
        write_vertex(1023, Q_HI, Q_HI, Q_LO);
        write_vertex(512,  Q_LO, Q_HI, Q_HI);
        write_vertex(341,  '0,   '0,   '0);
        write_vertex(682,  Q_ONE, '0,  '0);
        write_vertex(5,    '0,   Q_ONE, '0);
        write_vertex(1,    16'sd1, '0, '0);
        send_face(0, 0, 0, 1'b0);          // all three corners the same vertex
        send_face(341, 682, 5, 1'b0);      // unit right triangle
        send_face(0, 1023, 512, 1'b0);     // widest triangle
        send_face(1023, 0, 512, 1'b1);     // same with the winding reversed, ends the mesh
        send_face(341, 1, 5, 1'b1);        // smallest nonzero edge, a fresh mesh
        // Three points on one line give a zero area.
        write_vertex(100, '0, '0, '0);
        write_vertex(101, Q_ONE, Q_ONE, Q_ONE);
        write_vertex(102, 16'sh0200, 16'sh0200, 16'sh0200);
        send_face(100, 101, 102, 1'b0);
        // Rewriting a slot must replace its old vertex.
        write_vertex(341, Q_NEG, Q_LO, Q_HI);
        send_face(341, 682, 5, 1'b0);
        send_face(5, 341, 1, 1'b1);

        // A back to back burst of the widest triangle, then close the mesh.
        calm = 1'b1;
        for (int n = 0; n < WIDE_FACES; n++) begin
            send_face(0, 1023, 512, 1'b0);
        end
        send_face(0, 1023, 512, 1'b1);
        calm = 1'b0;
        wait_drained();

        // Random part: well-formed meshes over vertices that have been
        // written, with stores mixed in between faces. The tail runs calm.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            calm = (n >= RANDOM_ITEMS - CALM_TAIL);
            if ($urandom_range(0, 99) < 35) begin
                write_vertex($urandom_range(0, VERTEX_DEPTH - 1),
                             pick_coord(), pick_coord(), pick_coord());
            end else begin
                a = any_written_slot();
                b = any_written_slot();
                c = ($urandom_range(0, 9) == 0) ? a : any_written_slot();
                send_face(a, b, c, $urandom_range(0, 7) == 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
